FILE: design/pwom_pkg.sv
`default_nettype none

package pwom_pkg;

    // Pattern geometry; PATTERN_SIDE is a power of two.
    localparam int PATTERN_SIDE     = 256;
    localparam int FRAME_COORD_BITS = 12;

    localparam int SIDE_BITS   = $clog2(PATTERN_SIDE);
    localparam int ADDR_W      = 2 * SIDE_BITS;
    localparam int STORE_DEPTH = PATTERN_SIDE * PATTERN_SIDE;

    // Configured pattern sizes are 9 bits wide; effective sizes need SIDE_BITS + 1 bits, so DIM_W takes the wider.
    localparam int CFG_DIM_W = 9;
    localparam int DIM_W     = (SIDE_BITS + 1 > CFG_DIM_W) ? SIDE_BITS + 1 : CFG_DIM_W;

    localparam int PIX_W   = 12;
    localparam int ALPHA_W = 8;
    localparam int PADDR_W = 16;
    localparam int CFG_W   = 16;

    localparam int IN_DATA_W = 2 * PIX_W + PADDR_W + ALPHA_W;

    localparam int Q14_SHIFT = 14;

    typedef enum logic [2:0] {
        CFG_ZOOM_RECIP = 3'd0,
        CFG_OFFSET_X   = 3'd1,
        CFG_OFFSET_Y   = 3'd2,
        CFG_COSINE     = 3'd3,
        CFG_SINE       = 3'd4,
        CFG_PAT_WIDTH  = 3'd5,
        CFG_PAT_HEIGHT = 3'd6,
        CFG_INVERSE    = 3'd7
    } cfg_index_t;

    typedef enum logic {
        FUNC_WRITE = 1'b0,
        FUNC_QUERY = 1'b1
    } func_t;

endpackage

`default_nettype wire

FILE: design/pattern_wipe_opacity_map_core.sv
`default_nettype none

// Wipe-transition opacity lookup. Each input item either loads one alpha byte
// into the pattern store (tuser = 0) or asks for the opacity of one frame pixel
// (tuser = 1); only queries give a result item. The block takes one item every
// clock cycle while its skid stage is empty. The path is a fixed pipeline:
// offset subtract, zoom multiply, centre subtract, rotation multiplies, sum,
// truncation, then the single read/write access to the pattern store, whose
// read data is registered. Loads and queries share that one store access in
// arrival order, so a query always sees every earlier load. An output register
// with a skid stage keeps input flowing while a result waits; input stalls only
// once both are full. The store is not cleared: load every pattern entry a
// query may reach before querying it. Configuration must be written only while
// no item is in flight; the block itself does not enforce this.
module pattern_wipe_opacity_map_core (
    input  wire                         aclk,
    input  wire                         aresetn,
    // slave item channel
    input  wire                         s_tvalid,
    output logic                        s_tready,
    // pixel_x[11:0], pixel_y[23:12], pattern_address[39:24], alpha_value[47:40]
    input  wire [pwom_pkg::IN_DATA_W-1:0] s_tdata,
    // func[0]
    input  wire [0:0]                   s_tuser,
    // master result channel
    output logic                        m_tvalid,
    input  wire                         m_tready,
    // opacity[7:0]
    output logic [7:0]                  m_tdata,
    // configuration write channel
    input  wire                         cfg_valid,
    output logic                        cfg_ready,
    input  pwom_pkg::cfg_index_t        cfg_index,
    input  wire [pwom_pkg::CFG_W-1:0]   cfg_data
);
    import pwom_pkg::*;

    localparam int DX_W  = PIX_W + 6;      // pixel minus signed 16-bit offset
    localparam int MX_W  = DX_W + CFG_W + 1;
    localparam int RX_W  = MX_W - 8 + 1;
    localparam int PR_W  = RX_W + CFG_W;
    localparam int SUM_W = PR_W + 2;
    localparam int NX_W  = SUM_W - Q14_SHIFT;

    localparam logic [PIX_W-1:0] PIX_MASK = PIX_W'((1 << FRAME_COORD_BITS) - 1);
    localparam logic [SUM_W-1:0] TRUNC_BIAS = SUM_W'((1 << Q14_SHIFT) - 1);

    // configuration registers
    logic [CFG_W-1:0]        zoom_reg;
    logic signed [CFG_W-1:0] offset_x_reg, offset_y_reg, cosine_reg, sine_reg;
    logic [CFG_DIM_W-1:0]    pat_w_reg, pat_h_reg;
    logic                    inverse_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zoom_reg     <= CFG_W'(256);
            offset_x_reg <= '0;
            offset_y_reg <= '0;
            cosine_reg   <= CFG_W'(16384);
            sine_reg     <= '0;
            pat_w_reg    <= CFG_DIM_W'(256);
            pat_h_reg    <= CFG_DIM_W'(256);
            inverse_reg  <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_ZOOM_RECIP: zoom_reg     <= cfg_data;
                CFG_OFFSET_X:   offset_x_reg <= cfg_data;
                CFG_OFFSET_Y:   offset_y_reg <= cfg_data;
                CFG_COSINE:     cosine_reg   <= cfg_data;
                CFG_SINE:       sine_reg     <= cfg_data;
                CFG_PAT_WIDTH:  pat_w_reg    <= cfg_data[CFG_DIM_W-1:0];
                CFG_PAT_HEIGHT: pat_h_reg    <= cfg_data[CFG_DIM_W-1:0];
                CFG_INVERSE:    inverse_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // effective pattern size, saturated to the store side
    logic [DIM_W-1:0] w_eff, h_eff, ox, oy;

    always_comb begin
        w_eff = DIM_W'(pat_w_reg);
        h_eff = DIM_W'(pat_h_reg);
        if (w_eff > DIM_W'(PATTERN_SIDE)) w_eff = DIM_W'(PATTERN_SIDE);
        if (h_eff > DIM_W'(PATTERN_SIDE)) h_eff = DIM_W'(PATTERN_SIDE);
        ox = w_eff >> 1;
        oy = h_eff >> 1;
    end

    // pipeline control
    logic en;
    logic skid_vld_reg;

    assign en       = !skid_vld_reg;
    assign s_tready = en;

    // stage valids and item kind
    logic a_vld_reg, b_vld_reg, c_vld_reg, d_vld_reg, e_vld_reg, f_vld_reg, g_vld_reg;
    logic h_vld_reg;
    logic a_q_reg, b_q_reg, c_q_reg, d_q_reg, e_q_reg, f_q_reg, g_q_reg, h_q_reg;

    // load item payload travels alongside
    logic [PADDR_W-1:0] a_addr_reg, b_addr_reg, c_addr_reg, d_addr_reg, e_addr_reg;
    logic [PADDR_W-1:0] f_addr_reg, g_addr_reg;
    logic [ALPHA_W-1:0] a_alpha_reg, b_alpha_reg, c_alpha_reg, d_alpha_reg, e_alpha_reg;
    logic [ALPHA_W-1:0] f_alpha_reg, g_alpha_reg;

    // query datapath
    logic [PIX_W-1:0]        a_x_reg, a_y_reg;
    logic signed [DX_W-1:0]  b_dx_reg, b_dy_reg, b_dx_next, b_dy_next;
    logic signed [MX_W-1:0]  c_mx_reg, c_my_reg, c_mx_next, c_my_next;
    logic signed [RX_W-1:0]  d_rx_reg, d_ry_reg, d_rx_next, d_ry_next;
    logic signed [PR_W-1:0]  e_rc_reg, e_rs_reg, e_xs_reg, e_yc_reg;
    logic signed [SUM_W-1:0] f_nx_reg, f_ny_reg, f_nx_next, f_ny_next;
    logic signed [NX_W-1:0]  g_nx_reg, g_ny_reg;
    logic [SUM_W-1:0]        nx_biased, ny_biased;
    logic                    h_inside_reg, g_inside;
    logic [ADDR_W-1:0]       rd_addr, wr_addr;

    always_comb begin
        b_dx_next = $signed({6'b0, a_x_reg & PIX_MASK}) - DX_W'(offset_x_reg);
        b_dy_next = $signed({6'b0, a_y_reg & PIX_MASK}) - DX_W'(offset_y_reg);
        c_mx_next = b_dx_reg * $signed({1'b0, zoom_reg});
        c_my_next = b_dy_reg * $signed({1'b0, zoom_reg});
        // floor divide by 256 is an arithmetic shift
        d_rx_next = RX_W'(c_mx_reg >>> 8) - RX_W'($signed({1'b0, ox}));
        d_ry_next = RX_W'(c_my_reg >>> 8) - RX_W'($signed({1'b0, oy}));
        f_nx_next = SUM_W'(e_rc_reg) - SUM_W'(e_rs_reg)
                  + SUM_W'($signed({1'b0, ox, {Q14_SHIFT{1'b0}}}));
        f_ny_next = SUM_W'(e_xs_reg) + SUM_W'(e_yc_reg)
                  + SUM_W'($signed({1'b0, oy, {Q14_SHIFT{1'b0}}}));
        // truncation toward zero: bias negatives before the shift
        nx_biased = f_nx_reg + (f_nx_reg[SUM_W-1] ? TRUNC_BIAS : '0);
        ny_biased = f_ny_reg + (f_ny_reg[SUM_W-1] ? TRUNC_BIAS : '0);
        g_inside  = !g_nx_reg[NX_W-1] && (g_nx_reg[NX_W-2:0] < (NX_W-1)'(w_eff))
                 && !g_ny_reg[NX_W-1] && (g_ny_reg[NX_W-2:0] < (NX_W-1)'(h_eff));
        rd_addr   = {g_ny_reg[SIDE_BITS-1:0], g_nx_reg[SIDE_BITS-1:0]};
        wr_addr   = ADDR_W'(g_addr_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
            e_vld_reg <= 1'b0;
            f_vld_reg <= 1'b0;
            g_vld_reg <= 1'b0;
            h_vld_reg <= 1'b0;
        end else if (en) begin
            a_vld_reg <= s_tvalid;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
            d_vld_reg <= c_vld_reg;
            e_vld_reg <= d_vld_reg;
            f_vld_reg <= e_vld_reg;
            g_vld_reg <= f_vld_reg;
            h_vld_reg <= g_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_q_reg     <= (s_tuser[0] == FUNC_QUERY);
            a_x_reg     <= s_tdata[PIX_W-1:0];
            a_y_reg     <= s_tdata[2*PIX_W-1:PIX_W];
            a_addr_reg  <= s_tdata[2*PIX_W+PADDR_W-1:2*PIX_W];
            a_alpha_reg <= s_tdata[IN_DATA_W-1:2*PIX_W+PADDR_W];

            b_q_reg <= a_q_reg; b_addr_reg <= a_addr_reg; b_alpha_reg <= a_alpha_reg;
            b_dx_reg <= b_dx_next;
            b_dy_reg <= b_dy_next;

            c_q_reg <= b_q_reg; c_addr_reg <= b_addr_reg; c_alpha_reg <= b_alpha_reg;
            c_mx_reg <= c_mx_next;
            c_my_reg <= c_my_next;

            d_q_reg <= c_q_reg; d_addr_reg <= c_addr_reg; d_alpha_reg <= c_alpha_reg;
            d_rx_reg <= d_rx_next;
            d_ry_reg <= d_ry_next;

            e_q_reg <= d_q_reg; e_addr_reg <= d_addr_reg; e_alpha_reg <= d_alpha_reg;
            e_rc_reg <= d_rx_reg * cosine_reg;
            e_rs_reg <= d_ry_reg * sine_reg;
            e_xs_reg <= d_rx_reg * sine_reg;
            e_yc_reg <= d_ry_reg * cosine_reg;

            f_q_reg <= e_q_reg; f_addr_reg <= e_addr_reg; f_alpha_reg <= e_alpha_reg;
            f_nx_reg <= f_nx_next;
            f_ny_reg <= f_ny_next;

            g_q_reg <= f_q_reg; g_addr_reg <= f_addr_reg; g_alpha_reg <= f_alpha_reg;
            g_nx_reg <= $signed(nx_biased[SUM_W-1:Q14_SHIFT]);
            g_ny_reg <= $signed(ny_biased[SUM_W-1:Q14_SHIFT]);

            h_q_reg      <= g_q_reg;
            h_inside_reg <= g_inside;
        end
    end

    // pattern store: loads and queries reach it at the same stage, in order
    logic [ALPHA_W-1:0] store_mem [STORE_DEPTH];
    logic [ALPHA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (en && g_vld_reg && !g_q_reg) begin
            store_mem[wr_addr] <= g_alpha_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    // result formation and output register with skid
    logic [7:0] opacity_next;
    logic       produce;
    logic [7:0] out_data_reg, skid_data_reg;
    logic       out_vld_reg;

    always_comb begin
        opacity_next = h_inside_reg ? rd_data_reg : 8'd0;
        if (inverse_reg) opacity_next = 8'hFF - opacity_next;
        produce = en && h_vld_reg && h_q_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (skid_vld_reg) begin
            if (m_tready) begin
                skid_vld_reg <= 1'b0;
            end
        end else if (produce) begin
            if (out_vld_reg && !m_tready) begin
                skid_vld_reg <= 1'b1;
            end else begin
                out_vld_reg <= 1'b1;
            end
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_vld_reg) begin
            if (m_tready) out_data_reg <= skid_data_reg;
        end else if (produce) begin
            if (out_vld_reg && !m_tready) skid_data_reg <= opacity_next;
            else                          out_data_reg  <= opacity_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

FILE: sim/tb_pattern_wipe_opacity_map_core.sv
`default_nettype none

module tb_pattern_wipe_opacity_map_core;
    timeunit 1ns;
    timeprecision 1ps;

    import pwom_pkg::*;

    localparam int LIMIT = 200000;

    typedef struct {
        func_t                func;
        logic [PIX_W-1:0]     x;
        logic [PIX_W-1:0]     y;
        logic [PADDR_W-1:0]   paddr;
        logic [ALPHA_W-1:0]   alpha;
    } pixel_op_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata = '0;
    logic [0:0]             s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [7:0]             m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    cfg_index_t             cfg_index = CFG_ZOOM_RECIP;
    logic [CFG_W-1:0]       cfg_data = '0;

    // register copy, reset values
    logic [15:0]            zoom_rcp = 16'd256;
    logic signed [15:0]     off_x = '0;
    logic signed [15:0]     off_y = '0;
    logic signed [15:0]     cos_q14 = 16'sd16384;
    logic signed [15:0]     sin_q14 = '0;
    logic [8:0]             pat_w = 9'd256;
    logic [8:0]             pat_h = 9'd256;
    logic                   invert = 1'b0;

    logic [7:0]             alpha_mem [STORE_DEPTH];
    bit                     loaded [STORE_DEPTH];
    pixel_op_t              op_q[$];
    logic [7:0]             opacity_due[$];
    int                     mismatches = 0;
    bit                     calm = 1'b0;
    bit                     s_taken = 1'b0;

    // zoom, offset_x, offset_y, cosine, sine, width, height, inverse
    int preset_regs [1:6][8] = '{
        '{256,   0,      0,      16384,  0,      256, 256, 1},
        '{0,     -32768, 32767,  -16384, 16384,  300, 511, 0},
        '{65535, 32767,  -32768, 16384,  -16384, 1,   1,   1},
        '{128,   -300,   -50,    11585,  11585,  200, 100, 0},
        '{384,   100,    100,    32767,  -32768, 0,   17,  1},
        '{256,   0,      0,      0,      16384,  256, 256, 0}
    };

    pattern_wipe_opacity_map_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 aclk = ~aclk;

    // Store address that a frame pixel maps to, or -1 when it lands outside.
    function automatic int map_to_store(logic [PIX_W-1:0] x, logic [PIX_W-1:0] y);
        longint w, h, ox, oy, px, py, rx, ry, nx, ny;
        w = (pat_w > PATTERN_SIDE) ? PATTERN_SIDE : pat_w;
        h = (pat_h > PATTERN_SIDE) ? PATTERN_SIDE : pat_h;
        ox = w / 2;
        oy = h / 2;
        // arithmetic shift gives the floor
        px = ((longint'(x) - longint'(off_x)) * longint'(zoom_rcp)) >>> 8;
        py = ((longint'(y) - longint'(off_y)) * longint'(zoom_rcp)) >>> 8;
        rx = px - ox;
        ry = py - oy;
        nx = (rx * longint'(cos_q14) - ry * longint'(sin_q14) + ox * 16384) / 16384;
        ny = (rx * longint'(sin_q14) + ry * longint'(cos_q14) + oy * 16384) / 16384;
        if (nx >= 0 && nx < w && ny >= 0 && ny < h)
            return int'(ny * PATTERN_SIDE + nx);
        return -1;
    endfunction

    function automatic void push_load(int addr, int alpha);
        pixel_op_t op;
        op.func  = FUNC_WRITE;
        op.x     = PIX_W'($urandom);
        op.y     = PIX_W'($urandom);
        op.paddr = PADDR_W'(addr);
        op.alpha = ALPHA_W'(alpha);
        loaded[op.paddr] = 1'b1;
        op_q.push_back(op);
    endfunction

    // Loads the entry first when the query would reach one never written.
    function automatic void push_query(int x, int y);
        pixel_op_t op;
        int        addr;
        addr = map_to_store(PIX_W'(x), PIX_W'(y));
        if (addr >= 0 && !loaded[addr])
            push_load(addr, $urandom_range(255));
        op.func  = FUNC_QUERY;
        op.x     = PIX_W'(x);
        op.y     = PIX_W'(y);
        op.paddr = PADDR_W'($urandom);
        op.alpha = ALPHA_W'($urandom);
        op_q.push_back(op);
    endfunction

    function automatic void push_mixed(int n);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(99) < 30)
                push_load($urandom_range(STORE_DEPTH - 1), $urandom_range(255));
            else if ($urandom_range(3) == 0)
                push_query($urandom_range(4095), $urandom_range(4095));
            else
                push_query($urandom_range(600), $urandom_range(600));
        end
    endfunction

    task automatic drain();
        while (op_q.size() != 0 || s_tvalid || opacity_due.size() != 0)
            @(posedge aclk);
    endtask

    task automatic program_regs(int regs [8]);
        cfg_index_t idx;
        for (int i = 0; i < 8; i++) begin
            idx = cfg_index_t'(i);
            @(negedge aclk);
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= CFG_W'(regs[i]);
            do @(posedge aclk); while (!cfg_ready);
            case (idx)
                CFG_ZOOM_RECIP: zoom_rcp = 16'(regs[i]);
                CFG_OFFSET_X:   off_x    = 16'(regs[i]);
                CFG_OFFSET_Y:   off_y    = 16'(regs[i]);
                CFG_COSINE:     cos_q14  = 16'(regs[i]);
                CFG_SINE:       sin_q14  = 16'(regs[i]);
                CFG_PAT_WIDTH:  pat_w    = 9'(regs[i]);
                CFG_PAT_HEIGHT: pat_h    = 9'(regs[i]);
                CFG_INVERSE:    invert   = 1'(regs[i]);
                default: ;
            endcase
        end
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // sender and receiver
    always @(negedge aclk) begin : drive
        pixel_op_t op;
        if (aresetn && (!s_tvalid || s_taken)) begin
            if (op_q.size() != 0 && (calm || $urandom_range(99) >= 37)) begin
                op = op_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {op.alpha, op.paddr, op.y, op.x};
                s_tuser  <= op.func;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        m_tready <= calm || ($urandom_range(99) >= 37);
    end

    // prediction on accepted input, checking on accepted output
    always @(posedge aclk) begin : watch
        int         addr;
        logic [7:0] val;
        s_taken = aresetn && s_tvalid && s_tready;
        if (s_taken) begin
            if (func_t'(s_tuser[0]) == FUNC_WRITE) begin
                alpha_mem[s_tdata[39:24]] = s_tdata[47:40];
            end else begin
                addr = map_to_store(s_tdata[11:0], s_tdata[23:12]);
                val  = (addr >= 0) ? alpha_mem[addr] : 8'd0;
                opacity_due.push_back(invert ? 8'd255 - val : val);
            end
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (opacity_due.size() == 0) begin
                $error("opacity: unexpected result item, actual %0d", m_tdata);
                mismatches++;
            end else begin
                val = opacity_due.pop_front();
                if (m_tdata !== val) begin
                    $error("opacity mismatch: expected %0d, actual %0d", val, m_tdata);
                    mismatches++;
                end
            end
        end
    end

    initial begin : watchdog
        repeat (LIMIT) @(posedge aclk);
        $display("tb: failure");
        $finish;
    end

    initial begin : run
        int regs [8];
        int n;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int p = 0; p <= 10; p++) begin
            if (p > 0) begin
                drain();
                // loads give no result but may still be in the pipe
                repeat (16) @(posedge aclk);
                if (p <= 6) begin
                    regs = preset_regs[p];
                end else begin
                    regs[0] = $urandom_range(1024, 64);
                    regs[1] = int'($urandom_range(400)) - 200;
                    regs[2] = int'($urandom_range(400)) - 200;
                    regs[3] = int'($urandom_range(32768)) - 16384;
                    regs[4] = int'($urandom_range(32768)) - 16384;
                    regs[5] = $urandom_range(256, 1);
                    regs[6] = $urandom_range(256, 1);
                    regs[7] = $urandom_range(1);
                end
                program_regs(regs);
            end
            calm = (p == 6);
            if (p == 0) begin
                // identity mapping after reset: corners, edges, overwrite
                push_load(0, 0);
                push_load(STORE_DEPTH - 1, 255);
                push_query(0, 0);
                push_query(255, 255);
                push_query(4095, 4095);
                push_query(256, 0);
                push_query(0, 256);
                push_load(0, 255);
                push_query(0, 0);
                push_query(128, 64);
                push_load(16'h5AA5, 8'h5A);
                push_query(8'hA5, 8'h5A);
                push_load(16'hA55A, 8'hA5);
                push_query(8'h5A, 8'hA5);
            end else begin
                n = (p <= 6) ? 60 : 135;
                if (p == 3) begin
                    // sender holds off until every result is back
                    push_mixed(n / 2);
                    drain();
                    push_mixed(n - n / 2);
                end else begin
                    push_mixed(n);
                end
            end
        end

        drain();
        repeat (20) @(posedge aclk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire
